[src/asr_pkg.sv]
package asr_pkg;

  localparam int NUM_RANGES     = 5;
  localparam int ADC_FULL_SCALE = 65536;

  localparam int TABLE_ROWS = 5;
  localparam int CODE_W     = 16;
  localparam int RANGE_W    = 3;
  localparam int RES_W      = 25;
  localparam int PROD_W     = CODE_W + RES_W;
  localparam int TWICE_FS   = 2 * ADC_FULL_SCALE;
  localparam int DEN_W      = $clog2(TWICE_FS + 1);
  localparam int STEP_W     = $clog2(RES_W);

  localparam logic [RANGE_W-1:0] TOP_RANGE = RANGE_W'(NUM_RANGES - 1);
  localparam logic [RANGE_W-1:0] LAST_ROW  = RANGE_W'(TABLE_ROWS - 1);
  localparam logic [RES_W-1:0]   RS_SAT    = {RES_W{1'b1}};

  // depth must be a power of two so the pointers wrap on their own
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_SWITCH   = 3'd0,
    ST_VALID    = 3'd1,
    ST_ADC_OVER = 3'd2,
    ST_RS_OVER  = 3'd3,
    ST_UNDER    = 3'd4
  } status_t;

  typedef struct packed {
    logic [CODE_W-1:0] lo_limit;
    logic [RES_W-1:0]  rg;
    logic [CODE_W-1:0] hi_limit;
    logic [RES_W-1:0]  rs_max;
  } range_row_t;

  // ST_VALID marks a request that still needs the resistance computed
  typedef struct packed {
    status_t            kind;
    logic [RANGE_W-1:0] next_range;
    logic [RANGE_W-1:0] row;
    logic [CODE_W-1:0]  code;
  } request_t;

  function automatic range_row_t range_row(input logic [RANGE_W-1:0] row);
    range_row_t r;
    unique case (row)
      3'd0:    r = '{lo_limit: 16'd442,  rg: 25'd8870,     hi_limit: 16'd1922,
                     rs_max: 25'd132};
      3'd1:    r = '{lo_limit: 16'd393,  rg: 25'd39200,    hi_limit: 16'd10263,
                     rs_max: 25'd3330};
      3'd2:    r = '{lo_limit: 16'd3468, rg: 25'd110000,   hi_limit: 16'd56753,
                     rs_max: 25'd84000};
      3'd3:    r = '{lo_limit: 16'd3492, rg: 25'd2740000,  hi_limit: 16'd57175,
                     rs_max: 25'd2119971};
      default: r = '{lo_limit: 16'd7171, rg: 25'd33300000, hi_limit: 16'd62415,
                     rs_max: 25'd1909936};
    endcase
    return r;
  endfunction

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_CHK,
    BK_DIV,
    BK_FIN
  } back_state_t;

endpackage

[src/asr_front.sv]
module asr_front
  import asr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CODE_W-1:0] in_adc_code,
  input  logic              q_full,
  output logic              q_push,
  output request_t          q_req
);

  logic [RANGE_W-1:0] current_range_r;
  logic [RANGE_W-1:0] current_range_nxt;
  logic [RANGE_W-1:0] r;
  logic [RANGE_W-1:0] row;
  range_row_t         lim;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    r   = ({1'b0, current_range_r} >= (RANGE_W + 1)'(NUM_RANGES)) ? TOP_RANGE
                                                                  : current_range_r;
    row = ({1'b0, r} < (RANGE_W + 1)'(TABLE_ROWS)) ? r : LAST_ROW;
    lim = range_row(row);

    q_req.row  = row;
    q_req.code = in_adc_code;
    priority if (in_adc_code > lim.hi_limit) begin
      q_req.kind       = ST_ADC_OVER;
      q_req.next_range = TOP_RANGE;
    end else if (in_adc_code < lim.lo_limit) begin
      if (r == '0) begin
        q_req.kind       = ST_UNDER;
        q_req.next_range = TOP_RANGE;
      end else begin
        q_req.kind       = ST_SWITCH;
        q_req.next_range = r - RANGE_W'(1);
      end
    end else begin
      q_req.kind       = ST_VALID;
      q_req.next_range = TOP_RANGE;
    end

    current_range_nxt = q_push ? q_req.next_range : current_range_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_range_r <= TOP_RANGE;
    end else begin
      current_range_r <= current_range_nxt;
    end
  end

`ifndef SYNTH
  a_range_legal: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, current_range_r} < (RANGE_W + 1)'(NUM_RANGES))
    else $error("selected range beyond the last range");
`endif

endmodule

[src/asr_queue.sv]
module asr_queue
  import asr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  request_t push_req,
  output logic     full,
  input  logic     pop,
  output request_t pop_req,
  output logic     empty
);

  request_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r;
  logic [QCNT_W-1:0]  count_nxt;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pop_req = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("request pushed into a full queue");
`endif

endmodule

[src/asr_back.sv]
module asr_back
  import asr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  request_t           q_req,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [RANGE_W-1:0] out_range_select,
  output logic [RES_W-1:0]   out_gain_resistance,
  output logic [RES_W-1:0]   out_sensor_resistance
);

  back_state_t        state_r;
  back_state_t        state_nxt;
  request_t           req_r;
  request_t           req_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [PROD_W-1:0]  prod_nxt;
  logic [DEN_W-1:0]   den_r;
  logic [DEN_W-1:0]   den_nxt;
  logic               sat_r;
  logic               sat_nxt;
  logic [DEN_W-1:0]   rem_r;
  logic [DEN_W-1:0]   rem_nxt;
  logic [RES_W-1:0]   dvd_r;
  logic [RES_W-1:0]   dvd_nxt;
  logic [STEP_W-1:0]  step_r;
  logic [STEP_W-1:0]  step_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  status_t            status_r;
  status_t            status_nxt;
  logic [RANGE_W-1:0] range_r;
  logic [RANGE_W-1:0] range_nxt;
  logic [RES_W-1:0]   rg_r;
  logic [RES_W-1:0]   rg_nxt;
  logic [RES_W-1:0]   rs_r;
  logic [RES_W-1:0]   rs_nxt;

  range_row_t         lim;
  logic [DEN_W:0]     trial;
  logic               fits;
  logic               quot_wide;
  logic               take;

  assign take        = (state_r == BK_IDLE) && !q_empty && !out_valid_r;
  assign q_pop       = take;
  assign lim         = range_row(req_r.row);
  assign trial       = {rem_r, dvd_r[RES_W-1]};
  assign fits        = (trial >= {1'b0, den_r});
  // quotient needs more than RES_W bits when the high part already reaches the divisor
  assign quot_wide   = ((prod_r >> RES_W) >= PROD_W'(den_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (take && q_req.kind == ST_VALID) state_nxt = BK_MUL;
      BK_MUL:  state_nxt = BK_CHK;
      BK_CHK:  state_nxt = (sat_r || quot_wide) ? BK_FIN : BK_DIV;
      BK_DIV:  if (step_r == STEP_W'(RES_W - 1)) state_nxt = BK_FIN;
      BK_FIN:  state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    req_nxt       = req_r;
    prod_nxt      = prod_r;
    den_nxt       = den_r;
    sat_nxt       = sat_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    status_nxt    = status_r;
    range_nxt     = range_r;
    rg_nxt        = rg_r;
    rs_nxt        = rs_r;
    unique case (state_r)
      BK_IDLE: begin
        if (take) begin
          req_nxt = q_req;
          if (q_req.kind != ST_VALID) begin
            out_valid_nxt = 1'b1;
            status_nxt    = q_req.kind;
            range_nxt     = q_req.next_range;
            rg_nxt        = '0;
            rs_nxt        = '0;
          end
        end
      end
      BK_MUL: begin
        prod_nxt = PROD_W'(req_r.code) * PROD_W'(lim.rg);
        sat_nxt  = ({{(32 - CODE_W){1'b0}}, req_r.code} >= 32'(TWICE_FS));
        den_nxt  = DEN_W'(TWICE_FS) - DEN_W'(req_r.code);
      end
      BK_CHK: begin
        rem_nxt  = DEN_W'(prod_r >> RES_W);
        dvd_nxt  = prod_r[RES_W-1:0];
        step_nxt = '0;
        rs_nxt   = RS_SAT;
      end
      BK_DIV: begin
        // one quotient bit per cycle, shifted in where the dividend bit left
        rem_nxt  = fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
        dvd_nxt  = {dvd_r[RES_W-2:0], fits};
        step_nxt = step_r + STEP_W'(1);
        rs_nxt   = {dvd_r[RES_W-2:0], fits};
      end
      BK_FIN: begin
        out_valid_nxt = 1'b1;
        status_nxt    = (rs_r > lim.rs_max) ? ST_RS_OVER : ST_VALID;
        range_nxt     = req_r.next_range;
        rg_nxt        = lim.rg;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    prod_r   <= prod_nxt;
    den_r    <= den_nxt;
    sat_r    <= sat_nxt;
    rem_r    <= rem_nxt;
    dvd_r    <= dvd_nxt;
    step_r   <= step_nxt;
    status_r <= status_nxt;
    range_r  <= range_nxt;
    rg_r     <= rg_nxt;
    rs_r     <= rs_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_status            = status_r;
  assign out_range_select      = range_r;
  assign out_gain_resistance   = rg_r;
  assign out_sensor_resistance = rs_r;

`ifndef SYNTH
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !out_valid_r)
    else $error("result pending while a request is still in work");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("pop from an empty queue");

  a_zero_when_not_computed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_VALID && status_r != ST_RS_OVER)
      |-> (rg_r == '0 && rs_r == '0))
    else $error("resistance reported for a request that was not computed");

  a_result_follows_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_FIN) |=> (out_valid_r && state_r == BK_IDLE))
    else $error("computed result not presented");
`endif

endmodule

[src/autorange_sensor_resistance.sv]
// Gain auto-ranging resistance meter. Each accepted ADC code is checked against
// the limits of the gain range currently selected (reset selects the highest).
// A code below the lower limit returns status "switch range" with the next lower
// range in range_select (status "under" in the lowest range); every other status
// returns range_select to the highest range. In-range codes give Rs = floor(code *
// Rg / (2 * full scale - code)), saturated to all ones. Range selection happens at
// input acceptance, so codes are accepted back to back while a two-entry queue has
// room. Out-of-range codes are presented in the cycle after they leave the queue;
// a computed result passes through pop, multiply, overflow check, 25 steps of a
// bit-serial restoring divider (skipped on overflow) and result load.
module autorange_sensor_resistance
  import asr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CODE_W-1:0]  in_adc_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic [RANGE_W-1:0] out_range_select,
  output logic [RES_W-1:0]   out_gain_resistance,
  output logic [RES_W-1:0]   out_sensor_resistance
);

  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  request_t push_req;
  request_t pop_req;

  asr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_adc_code (in_adc_code),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_req       (push_req)
  );

  asr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .pop_req  (pop_req),
    .empty    (q_empty)
  );

  asr_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .q_req                 (pop_req),
    .q_pop                 (q_pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_range_select      (out_range_select),
    .out_gain_resistance   (out_gain_resistance),
    .out_sensor_resistance (out_sensor_resistance)
  );

endmodule
